>>> rtl/sawl_pkg.sv
`default_nettype none

package sawl_pkg;

  // Largest program payload that is held; longer frames are dropped.
  localparam int unsigned MAX_PAYLOAD_BYTES = 250;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W  = 16;

  // request actions
  localparam logic [1:0] ACT_RX_FRAME = 2'd0;
  localparam logic [1:0] ACT_SEND     = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;
  localparam logic [1:0] ACT_TAKE     = 2'd3;

  // received frame kinds; anything but ack and program is "other"
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_PROGRAM = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // transmitted frame kinds
  localparam logic TX_KIND_ACK     = 1'b0;
  localparam logic TX_KIND_MESSAGE = 1'b1;

  // status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_DISABLED    = 2'd1;
  localparam logic [1:0] STAT_REFUSED     = 2'd2;
  localparam logic [1:0] STAT_ACK_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LINK_ENABLED  = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_ATTEMPT_LIMIT = 2'd2;

  localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd100;
  localparam logic [7:0]  ATTEMPT_LIMIT_RESET = 8'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic              frame_good;
    logic [1:0]        frame_kind;
    logic [SEQ_W-1:0]  frame_seq;
    logic [7:0]        frame_len;
    logic [ADDR_W-1:0] source_addr;
    logic [7:0]        message_byte;
    logic              send_accepted;
    logic [7:0]        take_capacity;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic              tx_kind;
    logic [SEQ_W-1:0]  tx_seq;
    logic              tx_broadcast;
    logic [ADDR_W-1:0] tx_addr;
    logic [7:0]        tx_byte;
    logic              program_accepted;
    logic [7:0]        taken_len;
    logic [1:0]        status;
    logic              awaiting_ack;
  } result_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  next_seq;
    logic [SEQ_W-1:0]  last_rx_seq;
    logic              last_rx_valid;
    logic [ADDR_W-1:0] remote_addr;
    logic              peer_known;
    logic              held_flag;
    logic [7:0]        held_len;
    logic [SEQ_W-1:0]  pending_seq;
    logic [7:0]        pending_byte;
    logic [7:0]        attempts;
    logic [15:0]       elapsed_ms;
    logic              waiting;
  } state_t;

  typedef struct packed {
    logic        link_enabled;
    logic [15:0] ack_timeout_ms;
    logic [7:0]  attempt_limit;
  } cfg_t;

  // reset images: sequence numbering starts at 1, all other link state clear; config takes its defaults
  localparam state_t STATE_RESET = '{next_seq: 16'd1, default: '0};
  localparam cfg_t   CFG_RESET   = '{link_enabled:   1'b0,
                                     ack_timeout_ms: ACK_TIMEOUT_RESET,
                                     attempt_limit:  ATTEMPT_LIMIT_RESET};

endpackage

`default_nettype wire

>>> rtl/sawl_in_stage.sv
`default_nettype none

module sawl_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire sawl_pkg::item_t in_item,
  input  wire logic            advance,
  output logic                 item_valid,
  output sawl_pkg::item_t      item
);

  logic item_valid_next;

  assign in_ready = !item_valid || advance;

  always_comb begin
    item_valid_next = item_valid;
    if (in_valid && in_ready) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sawl_step.sv
`default_nettype none

module sawl_step #(
  parameter int unsigned MAX_PAYLOAD_BYTES = sawl_pkg::MAX_PAYLOAD_BYTES
) (
  input  wire sawl_pkg::item_t  item,
  input  wire sawl_pkg::state_t st,
  input  wire sawl_pkg::cfg_t   cfg,
  output sawl_pkg::state_t      st_next,
  output sawl_pkg::result_t     res
);

  logic        len_ok;
  logic        dup;
  logic [15:0] elapsed_inc;

  assign len_ok = (item.frame_len != 8'd0) &&
                  (item.frame_len <= 8'(MAX_PAYLOAD_BYTES));
  assign dup = st.last_rx_valid && (item.frame_seq == st.last_rx_seq);
  assign elapsed_inc = (st.elapsed_ms < cfg.ack_timeout_ms) ?
                       st.elapsed_ms + 16'd1 : st.elapsed_ms;

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (item.action)
      sawl_pkg::ACT_RX_FRAME: begin
        if (item.frame_good) begin
          st_next.remote_addr = item.source_addr;
          st_next.peer_known  = 1'b1;
          if (item.frame_kind == sawl_pkg::KIND_ACK) begin
            if (st.waiting && (item.frame_seq == st.pending_seq)) begin
              st_next.waiting = 1'b0;
            end
          end else if (item.frame_kind == sawl_pkg::KIND_PROGRAM && len_ok) begin
            if (!dup && !st.held_flag) begin
              st_next.held_len      = item.frame_len;
              st_next.last_rx_seq   = item.frame_seq;
              st_next.last_rx_valid = 1'b1;
              st_next.held_flag     = 1'b1;
              res.program_accepted  = 1'b1;
            end
            res.tx_valid = 1'b1;
            res.tx_kind  = sawl_pkg::TX_KIND_ACK;
            res.tx_seq   = item.frame_seq;
            res.tx_addr  = item.source_addr;
          end
        end
      end
      sawl_pkg::ACT_SEND: begin
        if (!cfg.link_enabled) begin
          res.status = sawl_pkg::STAT_DISABLED;
        end else begin
          st_next.pending_seq  = st.next_seq;
          st_next.next_seq     = st.next_seq + 16'd1;
          st_next.pending_byte = item.message_byte;
          st_next.waiting      = item.send_accepted;
          st_next.attempts     = {7'd0, item.send_accepted};
          st_next.elapsed_ms   = 16'd0;
          res.tx_valid     = 1'b1;
          res.tx_kind      = sawl_pkg::TX_KIND_MESSAGE;
          res.tx_seq       = st.next_seq;
          res.tx_broadcast = !st.peer_known;
          res.tx_addr      = st.peer_known ? st.remote_addr : '0;
          res.tx_byte      = item.message_byte;
          if (!item.send_accepted) begin
            res.status = sawl_pkg::STAT_REFUSED;
          end
        end
      end
      sawl_pkg::ACT_TICK: begin
        if (st.waiting) begin
          st_next.elapsed_ms = elapsed_inc;
          if (elapsed_inc >= cfg.ack_timeout_ms) begin
            if (st.attempts >= cfg.attempt_limit) begin
              st_next.waiting = 1'b0;
              res.status      = sawl_pkg::STAT_ACK_TIMEOUT;
            end else begin
              st_next.attempts   = st.attempts + 8'd1;
              st_next.elapsed_ms = 16'd0;
              // retransmit the pending message
              res.tx_valid     = 1'b1;
              res.tx_kind      = sawl_pkg::TX_KIND_MESSAGE;
              res.tx_seq       = st.pending_seq;
              res.tx_broadcast = !st.peer_known;
              res.tx_addr      = st.peer_known ? st.remote_addr : '0;
              res.tx_byte      = st.pending_byte;
            end
          end
        end
      end
      sawl_pkg::ACT_TAKE: begin
        if (st.held_flag) begin
          res.taken_len     = (st.held_len < item.take_capacity) ?
                              st.held_len : item.take_capacity;
          st_next.held_flag = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.awaiting_ack = st_next.waiting;
  end

endmodule

`default_nettype wire

>>> rtl/sawl_out_stage.sv
`default_nettype none

module sawl_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire sawl_pkg::result_t res_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sawl_pkg::result_t      res
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stop_and_wait_link_endpoint_unit.sv
// Channel    Handshake               Payload
// ---------  ----------------------  ------------------------------------------
// request    in_valid / in_ready     action, frame_*, source_addr, message_byte,
//                                    send_accepted, take_capacity
// result     out_valid / out_ready   tx_*, program_accepted, taken_len, status,
//                                    awaiting_ack
// config     cfg_valid / cfg_ready   cfg_index, cfg_data (low bits used except for timeout)
//
// An accepted request is held in the input register and is then loaded
// through the decision logic into the result register, from which its
// result is taken.
// A new request is accepted every cycle while results are drained.
// rst (synchronous) clears all link state, next_seq to 1, config to defaults.
// A stalled result holds the result register; the input register still takes
// one more request, then in_ready drops until the result is taken.
`default_nettype none

module stop_and_wait_link_endpoint_unit #(
  parameter int unsigned MAX_PAYLOAD_BYTES = sawl_pkg::MAX_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,

  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic        frame_good,
  input  wire logic [1:0]  frame_kind,
  input  wire logic [15:0] frame_seq,
  input  wire logic [7:0]  frame_len,
  input  wire logic [47:0] source_addr,
  input  wire logic [7:0]  message_byte,
  input  wire logic        send_accepted,
  input  wire logic [7:0]  take_capacity,

  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tx_valid,
  output logic             tx_kind,
  output logic [15:0]      tx_seq,
  output logic             tx_broadcast,
  output logic [47:0]      tx_addr,
  output logic [7:0]       tx_byte,
  output logic             program_accepted,
  output logic [7:0]       taken_len,
  output logic [1:0]       status,
  output logic             awaiting_ack,

  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  sawl_pkg::item_t   in_item;
  sawl_pkg::item_t   item;
  logic              item_valid;
  logic              advance;
  sawl_pkg::state_t  st;
  sawl_pkg::state_t  st_next;
  sawl_pkg::cfg_t    cfg;
  sawl_pkg::result_t step_res;
  sawl_pkg::result_t res;

  assign in_item.action        = action;
  assign in_item.frame_good    = frame_good;
  assign in_item.frame_kind    = frame_kind;
  assign in_item.frame_seq     = frame_seq;
  assign in_item.frame_len     = frame_len;
  assign in_item.source_addr   = source_addr;
  assign in_item.message_byte  = message_byte;
  assign in_item.send_accepted = send_accepted;
  assign in_item.take_capacity = take_capacity;

  // The held request moves on (and commits its state update) whenever the
  // result register is empty or being drained this cycle.
  assign advance = item_valid && (!out_valid || out_ready);

  sawl_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sawl_step #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (step_res)
  );

  sawl_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Link state: updated only when a request retires into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sawl_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Config registers; writes are always taken. Unused index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sawl_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sawl_pkg::CFG_LINK_ENABLED:  cfg.link_enabled   <= cfg_data[0];
        sawl_pkg::CFG_ACK_TIMEOUT:   cfg.ack_timeout_ms <= cfg_data;
        sawl_pkg::CFG_ATTEMPT_LIMIT: cfg.attempt_limit  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign tx_valid         = res.tx_valid;
  assign tx_kind          = res.tx_kind;
  assign tx_seq           = res.tx_seq;
  assign tx_broadcast     = res.tx_broadcast;
  assign tx_addr          = res.tx_addr;
  assign tx_byte          = res.tx_byte;
  assign program_accepted = res.program_accepted;
  assign taken_len        = res.taken_len;
  assign status           = res.status;
  assign awaiting_ack     = res.awaiting_ack;

endmodule

`default_nettype wire
